@@ design/min_tracking_stack_defines.svh @@
// Assertion macros for the min-tracking stack.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("min_tracking_stack: check failed");

// Next-cycle implication.
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("min_tracking_stack: check failed");

`endif

@@ design/mts_pkg.sv @@
package mts_pkg;

  localparam int unsigned OUT_W   = 32;
  localparam int unsigned DEPTH_W = 9;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] top_value;
    logic signed [OUT_W-1:0] min_value;
    logic [DEPTH_W-1:0]      depth_used;
    logic                    is_empty;
    logic [1:0]              status;
  } result_t;

  // Core to top level: control status.
  typedef struct packed {
    logic idle;  // ready to take a request
    logic done;  // result is valid this cycle
  } core_stat_t;

endpackage

@@ design/mts_ifaces.sv @@
interface mts_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      operation;
  logic signed [mts_pkg::OUT_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface mts_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [mts_pkg::OUT_W-1:0]   top_value;
  logic signed [mts_pkg::OUT_W-1:0]   min_value;
  logic [mts_pkg::DEPTH_W-1:0]        depth_used;
  logic                               is_empty;
  logic [1:0]                         status;

  modport source (output valid, output top_value, output min_value, output depth_used,
                  output is_empty, output status, input ready);
  modport sink (input valid, input top_value, input min_value, input depth_used,
                input is_empty, input status, output ready);
endinterface

@@ design/mts_ram.sv @@
module mts_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/mts_core.sv @@
module mts_core #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      operation,
  input  logic signed [mts_pkg::OUT_W-1:0] value,
  // element store
  output logic                            e_we,
  output logic [AW-1:0]                   e_waddr,
  output logic [WIDTH-1:0]                e_wdata,
  output logic [AW-1:0]                   e_raddr,
  input  logic [WIDTH-1:0]                e_rdata,
  // minimum store: {value, count}
  output logic                            m_we,
  output logic [AW-1:0]                   m_waddr,
  output logic [WIDTH+CW-1:0]             m_wdata,
  output logic [AW-1:0]                   m_raddr,
  input  logic [WIDTH+CW-1:0]             m_rdata,
  output mts_pkg::result_t                res,
  output mts_pkg::core_stat_t             stat
);

  typedef enum logic {IDLE, POP_WAIT} state_t;

  state_t                  state, state_next;
  logic [CW-1:0]           ep, ep_next;
  logic [CW-1:0]           mp, mp_next;
  logic signed [WIDTH-1:0] top_q, top_next;
  logic signed [WIDTH-1:0] mval_q, mval_next;
  logic [CW-1:0]           mcnt_q, mcnt_next;
  logic                    drop_q, drop_next;
  logic                    done;
  logic [1:0]              status_next;
  logic signed [WIDTH-1:0] v_w;

  assign v_w     = WIDTH'(value);
  // Entry below the top: needed only after a pop.
  assign e_raddr = AW'(ep - CW'(2));
  assign m_raddr = AW'(mp - CW'(2));

  always_comb begin
    state_next  = state;
    ep_next     = ep;
    mp_next     = mp;
    top_next    = top_q;
    mval_next   = mval_q;
    mcnt_next   = mcnt_q;
    drop_next   = drop_q;
    done        = 1'b0;
    status_next = mts_pkg::ST_OK;
    e_we        = 1'b0;
    e_waddr     = AW'(ep);
    e_wdata     = v_w;
    m_we        = 1'b0;
    m_waddr     = AW'(mp);
    m_wdata     = {v_w, CW'(1)};

    case (state)
      IDLE: begin
        if (start) begin
          case (operation)
            mts_pkg::OP_PUSH: begin
              done = 1'b1;
              if (ep == CW'(DEPTH)) begin
                status_next = mts_pkg::ST_OVERFLOW;
              end else begin
                e_we     = 1'b1;
                top_next = v_w;
                ep_next  = ep + CW'(1);
                if (mp == '0 || v_w < mval_q) begin
                  m_we      = 1'b1;
                  mval_next = v_w;
                  mcnt_next = CW'(1);
                  mp_next   = mp + CW'(1);
                end else if (v_w == mval_q) begin
                  mcnt_next = mcnt_q + CW'(1);
                  m_we      = 1'b1;
                  m_waddr   = AW'(mp - CW'(1));
                  m_wdata   = {mval_q, mcnt_next};
                end
              end
            end
            mts_pkg::OP_POP: begin
              if (ep == '0) begin
                done        = 1'b1;
                status_next = mts_pkg::ST_UNDERFLOW;
              end else begin
                ep_next    = ep - CW'(1);
                drop_next  = 1'b0;
                state_next = POP_WAIT;
                if (mp != '0 && top_q == mval_q) begin
                  if (mcnt_q == CW'(1)) begin
                    mp_next   = mp - CW'(1);
                    drop_next = 1'b1;
                  end else begin
                    mcnt_next = mcnt_q - CW'(1);
                    m_we      = 1'b1;
                    m_waddr   = AW'(mp - CW'(1));
                    m_wdata   = {mval_q, mcnt_next};
                  end
                end
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      POP_WAIT: begin
        done       = 1'b1;
        state_next = IDLE;
        top_next   = e_rdata;
        if (drop_q && mp != '0) begin
          mval_next = m_rdata[WIDTH+CW-1:CW];
          mcnt_next = m_rdata[CW-1:0];
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_comb begin
    res.top_value  = (ep_next == '0) ? '0 : mts_pkg::OUT_W'(top_next);
    res.min_value  = (mp_next == '0) ? '0 : mts_pkg::OUT_W'(mval_next);
    res.depth_used = mts_pkg::DEPTH_W'(ep_next);
    res.is_empty   = (ep_next == '0);
    res.status     = status_next;
    stat.idle      = (state == IDLE);
    stat.done      = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      ep     <= '0;
      mp     <= '0;
      drop_q <= 1'b0;
    end else begin
      state  <= state_next;
      ep     <= ep_next;
      mp     <= mp_next;
      drop_q <= drop_next;
    end
    top_q  <= top_next;
    mval_q <= mval_next;
    mcnt_q <= mcnt_next;
  end

endmodule

@@ design/min_tracking_stack.sv @@
// Push, peek and refused requests give their result in the output register in the cycle
//   after acceptance; a pop first reads the element store in core state POP_WAIT.
// Throughput: one push or peek per cycle while result.ready is high; none in POP_WAIT.
// Reset (rst, synchronous): both pointers and the output valid clear; the stores keep
//   their contents, no clearing pass, requests are taken as soon as reset is released.
`include "min_tracking_stack_defines.svh"

module min_tracking_stack #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  mts_req_if.sink   request,
  mts_res_if.source result
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Store ports
  logic                e_we;
  logic [AW-1:0]       e_waddr;
  logic [WIDTH-1:0]    e_wdata;
  logic [AW-1:0]       e_raddr;
  logic [WIDTH-1:0]    e_rdata;
  logic                m_we;
  logic [AW-1:0]       m_waddr;
  logic [WIDTH+CW-1:0] m_wdata;
  logic [AW-1:0]       m_raddr;
  logic [WIDTH+CW-1:0] m_rdata;

  mts_pkg::result_t    core_res;
  mts_pkg::core_stat_t core_stat;
  mts_pkg::result_t    out_q;
  logic                out_valid;
  logic                start;

  // Terms for the checks below
  logic                pop_held;
  logic                empty_zero;
  logic                ovf_seen;

  // A request is taken when the core is idle and the output slot is free or
  // being drained this cycle; the output register decouples the two sides.
  assign request.ready = core_stat.idle && (!out_valid || result.ready);
  assign start         = request.valid && request.ready;

  // Element store: one word per element, top copy cached in the core.
  mts_ram #(.DEPTH(DEPTH), .AW(AW), .DW(WIDTH)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // Minimum store: {value, repeat count}, written through on every change.
  mts_ram #(.DEPTH(DEPTH), .AW(AW), .DW(WIDTH + CW)) u_min_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  mts_core #(.DEPTH(DEPTH), .WIDTH(WIDTH), .AW(AW), .CW(CW)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .value     (request.value),
    .e_we      (e_we),
    .e_waddr   (e_waddr),
    .e_wdata   (e_wdata),
    .e_raddr   (e_raddr),
    .e_rdata   (e_rdata),
    .m_we      (m_we),
    .m_waddr   (m_waddr),
    .m_wdata   (m_wdata),
    .m_raddr   (m_raddr),
    .m_rdata   (m_rdata),
    .res       (core_res),
    .stat      (core_stat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_stat.done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (core_stat.done) begin
      out_q <= core_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.top_value  = out_q.top_value;
  assign result.min_value  = out_q.min_value;
  assign result.depth_used = out_q.depth_used;
  assign result.is_empty   = out_q.is_empty;
  assign result.status     = out_q.status;

  // A pending result is the latest one, so its empty flag is the stack state.
  assign pop_held   = start && (request.operation == mts_pkg::OP_POP) &&
                      out_valid && !result.is_empty;
  assign empty_zero = (result.depth_used == '0) && (result.top_value == '0) &&
                      (result.min_value == '0);
  assign ovf_seen   = result.valid && (result.status == mts_pkg::ST_OVERFLOW);

  // A new request never lands while a result is stuck in the output slot.
  `MTS_ASSERT_NOW(a_no_overrun, start, !out_valid || result.ready)
  // A pop that is carried out holds off the next request for its read cycle.
  `MTS_ASSERT_NEXT(a_pop_interlock, pop_held, !request.ready)
  // An empty stack reports zero depth and zero top and minimum.
  `MTS_ASSERT_NOW(a_empty_zero, result.valid && result.is_empty, empty_zero)
  // A refused push is only reported on a full stack.
  `MTS_ASSERT_NOW(a_overflow_full, ovf_seen, result.depth_used == mts_pkg::DEPTH_W'(DEPTH))

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int unsigned STACK_DEPTH  = 256;   // matches the DUT default DEPTH
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no handshake on either side
  localparam int unsigned DRAIN_CYCLES = 8;     // margin after the last result is checked

  // The package names only three operation codes; the fourth decodes as a peek.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // ---------------------------------------------------------------------------
  // Scoreboard: shadow stack plus minimum-entry stack, expected results in order
  // ---------------------------------------------------------------------------
  class min_stack_scoreboard;
    logic signed [mts_pkg::OUT_W-1:0] elems      [STACK_DEPTH];
    logic signed [mts_pkg::OUT_W-1:0] mins       [STACK_DEPTH];
    int unsigned                      min_repeats[STACK_DEPTH];
    int unsigned                      elem_count;
    int unsigned                      min_levels;
    mts_pkg::result_t                 expected_results[$];
    int unsigned                      failures;

    function new();
      elem_count = 0;
      min_levels = 0;
      failures   = 0;
    endfunction

    function void note_request(logic [1:0] operation,
                               logic signed [mts_pkg::OUT_W-1:0] value);
      mts_pkg::status_t                 st;
      mts_pkg::result_t                 exp;
      logic signed [mts_pkg::OUT_W-1:0] popped;
      st = mts_pkg::ST_OK;
      if (operation == mts_pkg::OP_PUSH) begin
        if (elem_count >= STACK_DEPTH) begin
          st = mts_pkg::ST_OVERFLOW;
        end else begin
          if (min_levels == 0 || value < mins[min_levels-1]) begin
            if (min_levels < STACK_DEPTH) begin
              mins[min_levels]        = value;
              min_repeats[min_levels] = 1;
              min_levels++;
            end
          end else if (value == mins[min_levels-1]) begin
            min_repeats[min_levels-1]++;
          end
          elems[elem_count] = value;
          elem_count++;
        end
      end else if (operation == mts_pkg::OP_POP) begin
        if (elem_count == 0) begin
          st = mts_pkg::ST_UNDERFLOW;
        end else begin
          popped = elems[elem_count-1];
          if (min_levels > 0) begin
            if (popped == mins[min_levels-1] && min_repeats[min_levels-1] > 0)
              min_repeats[min_levels-1]--;
            if (min_repeats[min_levels-1] == 0)
              min_levels--;
          end
          elem_count--;
        end
      end
      if (elem_count == 0) begin
        exp.top_value = '0;
        exp.min_value = '0;
      end else begin
        exp.top_value = elems[elem_count-1];
        exp.min_value = (min_levels > 0) ? mins[min_levels-1] : '0;
      end
      exp.depth_used = mts_pkg::DEPTH_W'(elem_count);
      exp.is_empty   = (elem_count == 0);
      exp.status     = st;
      expected_results.push_back(exp);
    endfunction

    function void check_result(logic signed [mts_pkg::OUT_W-1:0] top_value,
                               logic signed [mts_pkg::OUT_W-1:0] min_value,
                               logic [mts_pkg::DEPTH_W-1:0] depth_used,
                               logic is_empty, logic [1:0] status);
      mts_pkg::result_t exp;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      exp = expected_results.pop_front();
      if (top_value !== exp.top_value) begin
        $error("top_value expected %0d got %0d", exp.top_value, top_value);
        failures++;
      end
      if (min_value !== exp.min_value) begin
        $error("min_value expected %0d got %0d", exp.min_value, min_value);
        failures++;
      end
      if (depth_used !== exp.depth_used) begin
        $error("depth_used expected %0d got %0d", exp.depth_used, depth_used);
        failures++;
      end
      if (is_empty !== exp.is_empty) begin
        $error("is_empty expected %0b got %0b", exp.is_empty, is_empty);
        failures++;
      end
      if (status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, status);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mts_req_if req_if ();
  mts_res_if res_if ();

  min_tracking_stack u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if.sink),
    .result  (res_if.source)
  );

  min_stack_scoreboard sb = new();

  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 1;
  int unsigned gen_depth    = 0;   // stack depth as the stimulus side sees it
  int unsigned random_items = 0;

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the same edge, request noted first.
  // Results come from the output register, so a result can never belong to a request
  // accepted at that same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.operation, req_if.value);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.top_value, res_if.min_value, res_if.depth_used,
                        res_if.is_empty, res_if.status);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a hang shows up as a long run of edges with no handshake at all.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side backpressure: modes held for a random stretch -
  // always ready, coin flip, or mostly stalled.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_mode;
    int unsigned mode_left;
    stall_mode = 0;
    mode_left  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2, 0);
        mode_left  = $urandom_range(64, 16);
      end
      mode_left--;
      case (stall_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(1, 0));
        default: res_if.ready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Hold the request until the handshake, then maybe open a gap. Valid is
  // either re-driven high or dropped once per edge, never both.
  task automatic send_request(input logic [1:0] operation,
                              input logic signed [mts_pkg::OUT_W-1:0] value);
    int unsigned gap;
    req_if.valid     <= 1'b1;
    req_if.operation <= operation;
    req_if.value     <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(10, 0);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(4, 0) == 0) ? 300 : $urandom_range(24, 1);
    end
  endtask

  // Track depth on the stimulus side so phases know when the stack is full/empty.
  task automatic issue(input logic [1:0] operation,
                       input logic signed [mts_pkg::OUT_W-1:0] value);
    if (operation == mts_pkg::OP_PUSH && gen_depth < STACK_DEPTH)
      gen_depth++;
    else if (operation == mts_pkg::OP_POP && gen_depth > 0)
      gen_depth--;
    send_request(operation, value);
  endtask

  // Mostly a narrow band around zero so equal-to-minimum pushes are common,
  // some extremes, the rest full 32-bit random.
  function automatic logic signed [mts_pkg::OUT_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel < 5)
      return int'($urandom_range(16, 0)) - 8;
    if (sel == 5) begin
      case ($urandom_range(3, 0))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // push_pct biases push vs pop; about one request in ten is a peek,
  // a quarter of those with the undecoded op code.
  task automatic random_item(input int unsigned push_pct);
    logic [1:0]  operation;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 10)
      operation = ($urandom_range(3, 0) == 0) ? OP_RESERVED : mts_pkg::OP_PEEK;
    else if ($urandom_range(99, 0) < push_pct)
      operation = mts_pkg::OP_PUSH;
    else
      operation = mts_pkg::OP_POP;
    issue(operation, pick_value());
    random_items++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.operation <= mts_pkg::OP_PEEK;
    req_if.value     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-stack cases, extremes, repeated minimum, odd op code.
    issue(mts_pkg::OP_PEEK, 32'shffff_ffff);  // peek on empty -> zeros
    issue(mts_pkg::OP_POP,  32'sh7fff_ffff);  // underflow, state untouched
    issue(mts_pkg::OP_PUSH, 32'sh0000_0000);
    issue(mts_pkg::OP_PUSH, 32'sh7fff_ffff);  // above min, no new min entry
    issue(mts_pkg::OP_PUSH, 32'sh8000_0000);  // new minimum
    issue(mts_pkg::OP_PUSH, 32'sh8000_0000);  // same minimum, count goes to 2
    issue(mts_pkg::OP_PUSH, 32'shffff_ffff);
    issue(OP_RESERVED,      32'sh5555_5555);  // decodes as peek
    issue(mts_pkg::OP_PEEK, 32'shaaaa_aaaa);
    issue(mts_pkg::OP_POP,  32'sh1234_5678);  // pops -1, value ignored
    issue(mts_pkg::OP_POP,  32'sh0000_0000);  // min count 2 -> 1
    issue(mts_pkg::OP_POP,  32'sh0000_0000);  // min entry dropped, min back to 0
    issue(mts_pkg::OP_PUSH, 32'sh0000_0000);  // equal to current min
    issue(mts_pkg::OP_POP,  32'sh0000_0000);
    issue(mts_pkg::OP_POP,  32'sh0000_0000);
    issue(mts_pkg::OP_POP,  32'sh0000_0000);  // back to empty
    issue(mts_pkg::OP_POP,  32'shffff_ffff);  // underflow again

    // Random: fill to full (overflow a few times), wander, drain to empty
    // (underflow a few times), wander; repeat.
    while (random_items < RANDOM_ITEMS) begin
      while (gen_depth < STACK_DEPTH) random_item(85);
      repeat ($urandom_range(6, 2)) random_item(85);
      repeat ($urandom_range(80, 20)) random_item(50);
      while (gen_depth > 0) random_item(15);
      repeat ($urandom_range(6, 2)) random_item(15);
      repeat ($urandom_range(80, 20)) random_item(50);
    end
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
